// File: hw/rtl/trz_pkg.sv
package trz_pkg;

    localparam int MAX_WIDTH = 256;
    localparam int MAX_HEIGHT = 256;
    localparam int DEPTH_BITS = 24;
    localparam int XW = $clog2(MAX_WIDTH);
    localparam int YW = $clog2(MAX_HEIGHT);
    localparam int AW = XW + YW;
    localparam int STORE_SIZE = MAX_WIDTH * MAX_HEIGHT;
    localparam int DIM_W = 9;
    localparam int COORD_W = 16;
    localparam int COLOR_W = 24;
    localparam int ZIN_W = 24;
    localparam int CNT_W = 17;

    localparam logic [1:0] OP_DRAW = 2'd0;
    localparam logic [1:0] OP_READ = 2'd1;
    localparam logic [1:0] OP_CLEAR = 2'd2;

    localparam logic CFG_WIDTH = 1'b0;
    localparam logic CFG_HEIGHT = 1'b1;

    localparam logic [DEPTH_BITS-1:0] DEPTH_EMPTY = '1;

    typedef struct packed {
        logic [1:0] opcode;
        logic signed [COORD_W-1:0] ax;
        logic signed [COORD_W-1:0] ay;
        logic [ZIN_W-1:0] az;
        logic signed [COORD_W-1:0] bx;
        logic signed [COORD_W-1:0] by_coord;
        logic [ZIN_W-1:0] bz;
        logic signed [COORD_W-1:0] cx_coord;
        logic signed [COORD_W-1:0] cy_coord;
        logic [ZIN_W-1:0] cz;
        logic [COLOR_W-1:0] fill_color;
    } draw_word_t;

    typedef struct packed {
        logic [COLOR_W-1:0] read_color;
        logic [DEPTH_BITS-1:0] read_depth;
        logic [CNT_W-1:0] pixels_written;
        logic degenerate;
    } result_word_t;

    typedef struct packed {
        logic [1:0] index;
        logic [DIM_W-1:0] data;
    } cfg_word_t;

endpackage

// File: hw/rtl/trz_if.sv
interface trz_draw_if import trz_pkg::*; ();
    logic valid;
    logic ready;
    draw_word_t data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface trz_result_if import trz_pkg::*; ();
    logic valid;
    logic ready;
    result_word_t data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface trz_cfg_if import trz_pkg::*; ();
    logic valid;
    logic ready;
    cfg_word_t data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// File: hw/rtl/trz_divider.sv
module trz_divider import trz_pkg::*; (
    input  logic clk,
    input  logic rst_n,
    input  logic start,
    input  logic [79:0] num,
    input  logic [39:0] den,
    output logic busy,
    output logic [79:0] quot
);
    logic [6:0] cnt_reg, cnt_next;
    logic [79:0] q_reg, q_next;
    logic [40:0] r_reg, r_next;
    logic [39:0] d_reg, d_next;
    logic [41:0] trial;

    assign busy = (cnt_reg != 7'd0);
    assign quot = q_reg;

    always_comb
    begin
        cnt_next = cnt_reg;
        q_next = q_reg;
        r_next = r_reg;
        d_next = d_reg;
        trial = '0;
        if (start)
        begin
            cnt_next = 7'd80;
            q_next = num;
            r_next = '0;
            d_next = den;
        end
        else if (busy)
        begin
            trial = {r_reg, q_reg[79]} - {2'b00, d_reg};
            if (!trial[41])
            begin
                r_next = trial[40:0];
                q_next = {q_reg[78:0], 1'b1};
            end
            else
            begin
                r_next = {r_reg[39:0], q_reg[79]};
                q_next = {q_reg[78:0], 1'b0};
            end
            cnt_next = cnt_reg - 7'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cnt_reg <= '0;
        else
            cnt_reg <= cnt_next;
    end

    always_ff @(posedge clk)
    begin
        q_reg <= q_next;
        r_reg <= r_next;
        d_reg <= d_next;
    end
endmodule

// File: hw/rtl/triangle_rasterizer_zbuffer_top.sv
// Draws, reads or clears an internal 256 by 256 color and depth buffer, one word
// at a time; the input is not ready while a word is at work, and a finished result
// waits in its own output register so the next word can start. After reset, and for
// each clear, a clearing pass writes every entry, one per cycle. A read checks its
// pixel against the clamped size and reads the buffers in S_RD0, then picks its
// result in S_RD1. A draw finds the signed area and the clamped bounding box, then
// evaluates the edge functions for every pixel of the box on one shared 25 by 25
// multiplier; each covered pixel then takes the weighted depth sum, the 80 step
// restoring divide and its start, and the depth read-modify-write. S_OUT hands
// over the result once the output register is free. The divider sets the rate of
// filled pixels. Configuration writes are taken only while the block is idle.
module triangle_rasterizer_zbuffer_top import trz_pkg::*; (
    input  logic clk,
    input  logic rst_n,
    trz_draw_if.sink in_ch,
    trz_result_if.source out_ch,
    trz_cfg_if.sink cfg
);
    localparam logic [4:0] S_CLEAR = 5'd0;
    localparam logic [4:0] S_IDLE  = 5'd1;
    localparam logic [4:0] S_AREA0 = 5'd2;
    localparam logic [4:0] S_AREA1 = 5'd3;
    localparam logic [4:0] S_AREA2 = 5'd4;
    localparam logic [4:0] S_BOX   = 5'd5;
    localparam logic [4:0] S_E0A   = 5'd6;
    localparam logic [4:0] S_E0B   = 5'd7;
    localparam logic [4:0] S_E1A   = 5'd8;
    localparam logic [4:0] S_E1B   = 5'd9;
    localparam logic [4:0] S_TEST  = 5'd10;
    localparam logic [4:0] S_N0    = 5'd11;
    localparam logic [4:0] S_N1    = 5'd12;
    localparam logic [4:0] S_N2    = 5'd13;
    localparam logic [4:0] S_DIV   = 5'd14;
    localparam logic [4:0] S_DWAIT = 5'd15;
    localparam logic [4:0] S_RMW   = 5'd16;
    localparam logic [4:0] S_NEXT  = 5'd17;
    localparam logic [4:0] S_RD0   = 5'd18;
    localparam logic [4:0] S_RD1   = 5'd19;
    localparam logic [4:0] S_OUT   = 5'd20;
    localparam logic [4:0] S_DRD   = 5'd21;

    logic [DEPTH_BITS-1:0] depth_mem [STORE_SIZE];
    logic [COLOR_W-1:0] color_mem [STORE_SIZE];

    logic [4:0] state_reg, state_next;
    logic [AW:0] clr_reg, clr_next;
    logic [DIM_W-1:0] width_reg, height_reg;
    draw_word_t item_reg, item_next;
    logic signed [39:0] area_reg, area_next;
    logic signed [39:0] acc_reg, acc_next;
    logic signed [39:0] e0_reg, e0_next, e1_reg, e1_next;
    logic [79:0] num_reg, num_next;
    logic signed [XW+1:0] x_reg, x_next, x0_reg, x0_next, x1_reg, x1_next;
    logic signed [YW+1:0] y_reg, y_next, y1_reg, y1_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic neg_reg, neg_next;
    logic outv_reg, outv_next;
    result_word_t res_reg, res_next;
    result_word_t out_reg, out_next;
    logic [DEPTH_BITS-1:0] rd_depth_reg;
    logic [COLOR_W-1:0] rd_color_reg;
    logic [DEPTH_BITS-1:0] z_reg, z_next;
    logic rd_ok_reg, rd_ok_next;

    logic signed [24:0] mul_a, mul_b;
    logic signed [49:0] mul_p;
    logic signed [19:0] px, py;
    logic signed [16:0] dxb, dyc, dxc, dyb, dxa, dya;
    logic signed [COORD_W-1:0] mnx, mxx, mny, mxy;
    logic signed [XW+1:0] wm1, fx0, fx1;
    logic signed [YW+1:0] hm1, fy0, fy1;
    logic [DIM_W-1:0] w_eff, h_eff;
    logic signed [39:0] e2;
    logic [39:0] amag;
    logic div_start, div_busy;
    logic [79:0] div_q, div_num;
    logic [AW-1:0] addr;
    logic mem_we;
    logic [DEPTH_BITS-1:0] wr_depth;
    logic [COLOR_W-1:0] wr_color;

    trz_divider u_div (
        .clk(clk), .rst_n(rst_n), .start(div_start), .num(div_num),
        .den(amag), .busy(div_busy), .quot(div_q)
    );

    assign mul_p = mul_a * mul_b;
    assign amag = neg_reg ? 40'(-area_reg) : 40'(area_reg);
    assign e2 = $signed(amag) - e0_reg - e1_reg;
    assign div_num = num_reg + 80'(amag >> 1);

    assign w_eff = (width_reg == '0) ? DIM_W'(1) :
                   (width_reg > DIM_W'(MAX_WIDTH)) ? DIM_W'(MAX_WIDTH) : width_reg;
    assign h_eff = (height_reg == '0) ? DIM_W'(1) :
                   (height_reg > DIM_W'(MAX_HEIGHT)) ? DIM_W'(MAX_HEIGHT) : height_reg;
    assign wm1 = $signed({1'b0, (XW+1)'(w_eff - DIM_W'(1))});
    assign hm1 = $signed({1'b0, (YW+1)'(h_eff - DIM_W'(1))});

    assign px = $signed({x_reg, 4'b1000});
    assign py = $signed({y_reg, 4'b1000});
    assign dxa = 17'(item_reg.ax) - 17'(px);
    assign dya = 17'(item_reg.ay) - 17'(py);
    assign dxb = 17'(item_reg.bx) - 17'(px);
    assign dyb = 17'(item_reg.by_coord) - 17'(py);
    assign dxc = 17'(item_reg.cx_coord) - 17'(px);
    assign dyc = 17'(item_reg.cy_coord) - 17'(py);

    always_comb
    begin
        mnx = item_reg.ax;
        if (item_reg.bx < mnx) mnx = item_reg.bx;
        if (item_reg.cx_coord < mnx) mnx = item_reg.cx_coord;
        mxx = item_reg.ax;
        if (item_reg.bx > mxx) mxx = item_reg.bx;
        if (item_reg.cx_coord > mxx) mxx = item_reg.cx_coord;
        mny = item_reg.ay;
        if (item_reg.by_coord < mny) mny = item_reg.by_coord;
        if (item_reg.cy_coord < mny) mny = item_reg.cy_coord;
        mxy = item_reg.ay;
        if (item_reg.by_coord > mxy) mxy = item_reg.by_coord;
        if (item_reg.cy_coord > mxy) mxy = item_reg.cy_coord;
    end

    always_comb
    begin
        logic signed [12:0] f0, f1, g0, g1;
        f0 = 13'(mnx >>> 4);
        f1 = 13'((mxx + 16'sd15) >>> 4);
        g0 = 13'(mny >>> 4);
        g1 = 13'((mxy + 16'sd15) >>> 4);
        if (mxx > 16'sh7FF0) f1 = 13'sd2048;
        if (mxy > 16'sh7FF0) g1 = 13'sd2048;
        fx0 = (f0 < 0) ? '0 : (f0 > 13'(wm1) + 13'sd1) ? wm1 + (XW+2)'(1) : (XW+2)'(f0);
        fy0 = (g0 < 0) ? '0 : (g0 > 13'(hm1) + 13'sd1) ? hm1 + (YW+2)'(1) : (YW+2)'(g0);
        fx1 = (f1 > 13'(wm1)) ? wm1 : (f1 < -13'sd1) ? -(XW+2)'(1) : (XW+2)'(f1);
        fy1 = (g1 > 13'(hm1)) ? hm1 : (g1 < -13'sd1) ? -(YW+2)'(1) : (YW+2)'(g1);
    end

    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        case (state_reg)
            S_AREA0:
            begin
                mul_a = 25'(17'(item_reg.bx) - 17'(item_reg.ax));
                mul_b = 25'(17'(item_reg.cy_coord) - 17'(item_reg.ay));
            end
            S_AREA1:
            begin
                mul_a = 25'(17'(item_reg.cx_coord) - 17'(item_reg.ax));
                mul_b = 25'(17'(item_reg.by_coord) - 17'(item_reg.ay));
            end
            S_E0A: begin mul_a = 25'(dxb); mul_b = 25'(dyc); end
            S_E0B: begin mul_a = 25'(dxc); mul_b = 25'(dyb); end
            S_E1A: begin mul_a = 25'(dxc); mul_b = 25'(dya); end
            S_E1B: begin mul_a = 25'(dxa); mul_b = 25'(dyc); end
            default: begin mul_a = '0; mul_b = '0; end
        endcase
    end

    assign addr = (state_reg == S_CLEAR) ? clr_reg[AW-1:0] :
                  (state_reg == S_RD0) ?
                      {item_reg.ay[YW+3:4], item_reg.ax[XW+3:4]} :
                      {y_reg[YW-1:0], x_reg[XW-1:0]};

    always_comb
    begin
        logic [79:0] p0, p1;
        state_next = state_reg;
        clr_next = clr_reg;
        item_next = item_reg;
        area_next = area_reg;
        acc_next = acc_reg;
        e0_next = e0_reg;
        e1_next = e1_reg;
        num_next = num_reg;
        x_next = x_reg;
        x0_next = x0_reg;
        x1_next = x1_reg;
        y_next = y_reg;
        y1_next = y1_reg;
        cnt_next = cnt_reg;
        neg_next = neg_reg;
        outv_next = outv_reg;
        res_next = res_reg;
        out_next = out_reg;
        z_next = z_reg;
        rd_ok_next = rd_ok_reg;
        div_start = 1'b0;
        mem_we = 1'b0;
        wr_depth = z_reg;
        wr_color = item_reg.fill_color;
        p0 = '0;
        p1 = '0;
        if (outv_reg && out_ch.ready)
            outv_next = 1'b0;
        case (state_reg)
            S_CLEAR:
            begin
                mem_we = 1'b1;
                wr_depth = DEPTH_EMPTY;
                wr_color = '0;
                clr_next = clr_reg + 1'b1;
                if (clr_reg == (AW+1)'(STORE_SIZE - 1))
                    state_next = (item_reg.opcode == OP_CLEAR) ? S_OUT : S_IDLE;
            end
            S_IDLE:
            begin
                if (in_ch.valid)
                begin
                    item_next = in_ch.data;
                    res_next = '0;
                    cnt_next = '0;
                    case (in_ch.data.opcode)
                        OP_DRAW: state_next = S_AREA0;
                        OP_READ: state_next = S_RD0;
                        OP_CLEAR:
                        begin
                            clr_next = '0;
                            state_next = S_CLEAR;
                        end
                        default: state_next = S_OUT;
                    endcase
                end
            end
            S_AREA0:
            begin
                acc_next = 40'(mul_p);
                state_next = S_AREA1;
            end
            S_AREA1:
            begin
                area_next = acc_reg - 40'(mul_p);
                state_next = S_AREA2;
            end
            S_AREA2:
            begin
                neg_next = area_reg[39];
                if (area_reg == '0)
                begin
                    res_next.degenerate = 1'b1;
                    state_next = S_OUT;
                end
                else
                    state_next = S_BOX;
            end
            S_BOX:
            begin
                x0_next = fx0;
                x_next = fx0;
                x1_next = fx1;
                y_next = fy0;
                y1_next = fy1;
                if (fx0 > fx1 || fy0 > fy1)
                    state_next = S_OUT;
                else
                    state_next = S_E0A;
            end
            S_E0A: begin acc_next = 40'(mul_p); state_next = S_E0B; end
            S_E0B:
            begin
                e0_next = neg_reg ? -(acc_reg - 40'(mul_p)) : acc_reg - 40'(mul_p);
                state_next = S_E1A;
            end
            S_E1A: begin acc_next = 40'(mul_p); state_next = S_E1B; end
            S_E1B:
            begin
                e1_next = neg_reg ? -(acc_reg - 40'(mul_p)) : acc_reg - 40'(mul_p);
                state_next = S_TEST;
            end
            S_TEST:
            begin
                if (e0_reg[39] || e1_reg[39] || e2[39])
                    state_next = S_NEXT;
                else
                begin
                    num_next = '0;
                    state_next = S_N0;
                end
            end
            S_N0:
            begin
                p0 = 80'(e0_reg) * 80'(item_reg.az);
                num_next = p0;
                state_next = S_N1;
            end
            S_N1:
            begin
                p1 = 80'(e1_reg) * 80'(item_reg.bz);
                num_next = num_reg + p1;
                state_next = S_N2;
            end
            S_N2:
            begin
                p0 = 80'(e2) * 80'(item_reg.cz);
                num_next = num_reg + p0;
                state_next = S_DIV;
            end
            S_DIV:
            begin
                div_start = 1'b1;
                state_next = S_DWAIT;
            end
            S_DWAIT:
            begin
                if (!div_busy)
                begin
                    z_next = (div_q > 80'(DEPTH_EMPTY)) ? DEPTH_EMPTY
                                                        : div_q[DEPTH_BITS-1:0];
                    state_next = S_DRD;
                end
            end
            S_DRD: state_next = S_RMW;
            S_RMW:
            begin
                if (z_reg < rd_depth_reg)
                begin
                    mem_we = 1'b1;
                    cnt_next = cnt_reg + 1'b1;
                end
                state_next = S_NEXT;
            end
            S_NEXT:
            begin
                if (x_reg == x1_reg)
                begin
                    x_next = x0_reg;
                    if (y_reg == y1_reg)
                    begin
                        res_next.pixels_written = cnt_reg;
                        state_next = S_OUT;
                    end
                    else
                    begin
                        y_next = y_reg + 1'b1;
                        state_next = S_E0A;
                    end
                end
                else
                begin
                    x_next = x_reg + 1'b1;
                    state_next = S_E0A;
                end
            end
            S_RD0:
            begin
                rd_ok_next = !item_reg.ax[15] && !item_reg.ay[15]
                    && (item_reg.ax[15:4] < 12'(w_eff)) && (item_reg.ay[15:4] < 12'(h_eff));
                state_next = S_RD1;
            end
            S_RD1:
            begin
                res_next.read_color = rd_ok_reg ? rd_color_reg : '0;
                res_next.read_depth = rd_ok_reg ? rd_depth_reg : DEPTH_EMPTY;
                state_next = S_OUT;
            end
            S_OUT:
            begin
                if (!outv_reg || out_ch.ready)
                begin
                    out_next = res_reg;
                    outv_next = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    assign in_ch.ready = (state_reg == S_IDLE);
    assign out_ch.valid = outv_reg;
    assign out_ch.data = out_reg;
    assign cfg.ready = (state_reg == S_IDLE);

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            depth_mem[addr] <= wr_depth;
            color_mem[addr] <= wr_color;
        end
        rd_depth_reg <= depth_mem[addr];
        rd_color_reg <= color_mem[addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
            clr_reg <= '0;
            outv_reg <= 1'b0;
            width_reg <= DIM_W'(MAX_WIDTH);
            height_reg <= DIM_W'(MAX_HEIGHT);
            item_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            clr_reg <= clr_next;
            outv_reg <= outv_next;
            item_reg <= item_next;
            if (cfg.valid && cfg.ready && cfg.data.index == {1'b0, CFG_WIDTH})
                width_reg <= cfg.data.data;
            if (cfg.valid && cfg.ready && cfg.data.index == {1'b0, CFG_HEIGHT})
                height_reg <= cfg.data.data;
        end
    end

    always_ff @(posedge clk)
    begin
        area_reg <= area_next;
        acc_reg <= acc_next;
        e0_reg <= e0_next;
        e1_reg <= e1_next;
        num_reg <= num_next;
        x_reg <= x_next;
        x0_reg <= x0_next;
        x1_reg <= x1_next;
        y_reg <= y_next;
        y1_reg <= y1_next;
        cnt_reg <= cnt_next;
        neg_reg <= neg_next;
        res_reg <= res_next;
        out_reg <= out_next;
        z_reg <= z_next;
        rd_ok_reg <= rd_ok_next;
    end

    assert property (@(posedge clk) disable iff (!rst_n)
        in_ch.ready |-> state_reg == S_IDLE) else $error("ready outside idle");
    assert property (@(posedge clk) disable iff (!rst_n)
        mem_we && state_reg == S_RMW |-> z_reg != DEPTH_EMPTY)
        else $error("empty depth written");
    assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_DIV |=> div_busy) else $error("divider not started");
    assert property (@(posedge clk) disable iff (!rst_n)
        out_ch.valid && !out_ch.ready |=> out_ch.valid) else $error("result dropped");
    assert property (@(posedge clk) disable iff (!rst_n)
        out_ch.valid && !out_ch.ready |=> $stable(out_ch.data))
        else $error("result changed while waiting");
endmodule

// File: tb/sv/tb_top.sv
`timescale 1ns / 100ps

module tb_top;
    import trz_pkg::*;

    localparam logic [1:0] CFG_IDX_WIDTH = {1'b0, CFG_WIDTH};
    localparam logic [1:0] CFG_IDX_HEIGHT = {1'b0, CFG_HEIGHT};
    localparam logic [1:0] CFG_IDX_SPARE = 2'd2;
    localparam logic [1:0] CFG_IDX_TOP = 2'd3;
    localparam logic [1:0] OP_UNUSED = 2'd3;
    localparam int CYCLE_LIMIT = 40000000;

    logic clk;
    logic rst_n;

    trz_draw_if in_if();
    trz_result_if out_if();
    trz_cfg_if cfg_if();

    triangle_rasterizer_zbuffer_top dut (
        .clk(clk),
        .rst_n(rst_n),
        .in_ch(in_if),
        .out_ch(out_if),
        .cfg(cfg_if)
    );

    draw_word_t word_q[$];
    result_word_t expect_q[$];
    bit [DEPTH_BITS-1:0] zbuf [STORE_SIZE];
    bit [COLOR_W-1:0] cbuf [STORE_SIZE];
    bit [DIM_W-1:0] width_reg;
    bit [DIM_W-1:0] height_reg;
    int send_idle;
    int recv_idle;
    bit word_taken;
    int mismatches;
    longint cycles;
    int recent_x[$];
    int recent_y[$];

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic int eff_dim(bit [DIM_W-1:0] r, int maxv);
        if (r == 0)
            return 1;
        if (r > maxv)
            return maxv;
        return r;
    endfunction

    function automatic void clear_buffers();
        for (int i = 0; i < STORE_SIZE; i++)
        begin
            zbuf[i] = DEPTH_EMPTY;
            cbuf[i] = '0;
        end
    endfunction

    function automatic int floor_px(int v);
        return v >>> 4;
    endfunction

    function automatic result_word_t rasterize(draw_word_t w);
        result_word_t r;
        int xa, ya, xb, yb, xc, yc, wd, ht, x0, x1, y0, y1, idx;
        longint area, sgn, amag, px, py, e0, e1, e2;
        bit [63:0] num, z;
        r = '0;
        xa = $signed(w.ax);
        ya = $signed(w.ay);
        xb = $signed(w.bx);
        yb = $signed(w.by_coord);
        xc = $signed(w.cx_coord);
        yc = $signed(w.cy_coord);
        wd = eff_dim(width_reg, MAX_WIDTH);
        ht = eff_dim(height_reg, MAX_HEIGHT);
        case (w.opcode)
            OP_DRAW:
            begin
                area = longint'(xb - xa) * longint'(yc - ya) - longint'(xc - xa) * longint'(yb - ya);
                if (area == 0)
                begin
                    r.degenerate = 1'b1;
                    return r;
                end
                sgn = area > 0 ? 1 : -1;
                amag = area * sgn;
                x0 = floor_px(xa < xb ? (xa < xc ? xa : xc) : (xb < xc ? xb : xc));
                y0 = floor_px(ya < yb ? (ya < yc ? ya : yc) : (yb < yc ? yb : yc));
                x1 = (xa > xb ? (xa > xc ? xa : xc) : (xb > xc ? xb : xc)) + 15;
                y1 = (ya > yb ? (ya > yc ? ya : yc) : (yb > yc ? yb : yc)) + 15;
                x1 = floor_px(x1);
                y1 = floor_px(y1);
                if (x0 < 0) x0 = 0;
                if (y0 < 0) y0 = 0;
                if (x1 > wd - 1) x1 = wd - 1;
                if (y1 > ht - 1) y1 = ht - 1;
                for (int y = y0; y <= y1; y++)
                begin
                    py = longint'(y) * 16 + 8;
                    for (int x = x0; x <= x1; x++)
                    begin
                        px = longint'(x) * 16 + 8;
                        e0 = (xb - px) * (yc - py) - (xc - px) * (yb - py);
                        e1 = (xc - px) * (ya - py) - (xa - px) * (yc - py);
                        e0 = e0 * sgn;
                        e1 = e1 * sgn;
                        e2 = amag - e0 - e1;
                        if (e0 < 0 || e1 < 0 || e2 < 0)
                            continue;
                        num = e0 * w.az + e1 * w.bz + e2 * w.cz;
                        z = (num + amag / 2) / amag;
                        if (z > DEPTH_EMPTY)
                            z = DEPTH_EMPTY;
                        idx = y * MAX_WIDTH + x;
                        if (z[DEPTH_BITS-1:0] < zbuf[idx])
                        begin
                            zbuf[idx] = z[DEPTH_BITS-1:0];
                            cbuf[idx] = w.fill_color;
                            r.pixels_written++;
                        end
                    end
                end
            end
            OP_READ:
            begin
                x0 = floor_px(xa);
                y0 = floor_px(ya);
                if (x0 >= 0 && y0 >= 0 && x0 < wd && y0 < ht)
                begin
                    r.read_color = cbuf[y0 * MAX_WIDTH + x0];
                    r.read_depth = zbuf[y0 * MAX_WIDTH + x0];
                end
                else
                    r.read_depth = DEPTH_EMPTY;
            end
            OP_CLEAR:
                clear_buffers();
            default:
                r = '0;
        endcase
        return r;
    endfunction

    function automatic draw_word_t make_word(logic [1:0] op, int ax, int ay, int az,
                                             int bx, int by, int bz, int cx, int cy,
                                             int cz, int col);
        draw_word_t w;
        w.opcode = op;
        w.ax = ax[15:0];
        w.ay = ay[15:0];
        w.az = az[23:0];
        w.bx = bx[15:0];
        w.by_coord = by[15:0];
        w.bz = bz[23:0];
        w.cx_coord = cx[15:0];
        w.cy_coord = cy[15:0];
        w.cz = cz[23:0];
        w.fill_color = col[23:0];
        return w;
    endfunction

    function automatic int rand_depth();
        case ($urandom_range(9))
            0: return 0;
            1: return 24'hFFFFFF;
            default: return $urandom_range(24'hFFFFFF);
        endcase
    endfunction

    function automatic draw_word_t random_word(int wd, int ht);
        draw_word_t w;
        int pick, bx0, by0, ax, ay, bx, by, cx, cy;
        pick = $urandom_range(99);
        w = $urandom;
        w.az = rand_depth();
        w.bz = rand_depth();
        w.cz = rand_depth();
        w.fill_color = $urandom_range(24'hFFFFFF);
        if (pick < 2)
        begin
            w.opcode = OP_UNUSED;
            return w;
        end
        if (pick < 27)
        begin
            w.opcode = OP_READ;
            if (recent_x.size() > 0 && $urandom_range(3) != 0)
            begin
                pick = $urandom_range(recent_x.size() - 1);
                w.ax = 16'(recent_x[pick] + $urandom_range(32) - 16);
                w.ay = 16'(recent_y[pick] + $urandom_range(32) - 16);
            end
            else if ($urandom_range(3) != 0)
            begin
                w.ax = 16'($urandom_range(wd * 16 + 32) - 16);
                w.ay = 16'($urandom_range(ht * 16 + 32) - 16);
            end
            return w;
        end
        w.opcode = OP_DRAW;
        if (wd * ht <= 1024 && $urandom_range(6) == 0)
            return w;
        bx0 = $urandom_range(wd * 16 + 64) - 32;
        by0 = $urandom_range(ht * 16 + 64) - 32;
        ax = bx0 + $urandom_range(56);
        ay = by0 + $urandom_range(56);
        bx = bx0 + $urandom_range(56);
        by = by0 + $urandom_range(56);
        cx = bx0 + $urandom_range(56);
        cy = by0 + $urandom_range(56);
        if ($urandom_range(19) == 0)
        begin
            cx = 2 * bx - ax;
            cy = 2 * by - ay;
        end
        w.ax = 16'(ax);
        w.ay = 16'(ay);
        w.bx = 16'(bx);
        w.by_coord = 16'(by);
        w.cx_coord = 16'(cx);
        w.cy_coord = 16'(cy);
        recent_x.push_back(ax);
        recent_y.push_back(ay);
        if (recent_x.size() > 16)
        begin
            void'(recent_x.pop_front());
            void'(recent_y.pop_front());
        end
        return w;
    endfunction

    task automatic write_reg(logic [1:0] index, int value);
        @(negedge clk);
        cfg_if.valid <= 1'b1;
        cfg_if.data.index <= index;
        cfg_if.data.data <= value[DIM_W-1:0];
        @(posedge clk);
        while (!cfg_if.ready)
            @(posedge clk);
        if (index == CFG_IDX_WIDTH)
            width_reg = value[DIM_W-1:0];
        else if (index == CFG_IDX_HEIGHT)
            height_reg = value[DIM_W-1:0];
        @(negedge clk);
        cfg_if.valid <= 1'b0;
    endtask

    task automatic drain();
        while (word_q.size() > 0 || in_if.valid || expect_q.size() > 0)
            @(negedge clk);
    endtask

    task automatic random_run(int count);
        int wd, ht;
        wd = eff_dim(width_reg, MAX_WIDTH);
        ht = eff_dim(height_reg, MAX_HEIGHT);
        for (int i = 0; i < count; i++)
            word_q.push_back(random_word(wd, ht));
        drain();
    endtask

    initial
    begin
        rst_n = 1'b0;
        in_if.valid = 1'b0;
        in_if.data = '0;
        out_if.ready = 1'b0;
        cfg_if.valid = 1'b0;
        cfg_if.data = '0;
        width_reg = 9'd256;
        height_reg = 9'd256;
        send_idle = 33;
        recv_idle = 62;
        clear_buffers();
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        word_q.push_back(make_word(OP_READ, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
        word_q.push_back(make_word(OP_READ, 255 * 16 + 15, 255 * 16, 0, 0, 0, 0, 0, 0, 0, 0));
        word_q.push_back(make_word(OP_READ, -1, -1, 0, 0, 0, 0, 0, 0, 0, 0));
        word_q.push_back(make_word(OP_READ, 256 * 16, 0, 0, 0, 0, 0, 0, 0, 0, 0));
        word_q.push_back(make_word(OP_UNUSED, 5, 5, 7, 9, 9, 9, 1, 1, 1, 24'h123456));
        word_q.push_back(make_word(OP_DRAW, 16, 16, 5, 48, 48, 5, 80, 80, 5, 24'hFFFFFF));
        word_q.push_back(make_word(OP_DRAW, 0, 0, 100, 64, 0, 100, 0, 64, 100, 24'hFF0000));
        word_q.push_back(make_word(OP_DRAW, 0, 0, 50, 0, 64, 50, 64, 0, 50, 24'h00FF00));
        word_q.push_back(make_word(OP_DRAW, 0, 0, 50, 64, 0, 50, 0, 64, 50, 24'h0000FF));
        word_q.push_back(make_word(OP_DRAW, 80, 80, 24'hFFFFFF, 130, 80, 24'hFFFFFF,
                                   80, 130, 24'hFFFFFF, 24'hABCDEF));
        word_q.push_back(make_word(OP_DRAW, 0, 0, 0, 48, 0, 24'hFFFFFF, 0, 48, 0, 24'h0F0F0F));
        word_q.push_back(make_word(OP_READ, 16, 16, 0, 0, 0, 0, 0, 0, 0, 0));
        word_q.push_back(make_word(OP_DRAW, -32, -32, 9, 32, -32, 9, -32, 32, 9, 24'h808080));
        word_q.push_back(make_word(OP_DRAW, 4800, 4800, 3, 4864, 4800, 3, 4800, 4864, 3, 24'h1));
        word_q.push_back(make_word(OP_DRAW, 4051, 4052, 1000, 4095, 4060, 20,
                                   4070, 4095, 24'h800000, 24'hF0F0F0));
        word_q.push_back(make_word(OP_READ, 254 * 16 + 8, 254 * 16 + 8, 0, 0, 0, 0, 0, 0, 0, 0));
        word_q.push_back(make_word(OP_CLEAR, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
        word_q.push_back(make_word(OP_READ, 16, 16, 0, 0, 0, 0, 0, 0, 0, 0));
        drain();

        write_reg(CFG_IDX_WIDTH, 16);
        write_reg(CFG_IDX_HEIGHT, 16);
        word_q.push_back(make_word(OP_DRAW, -32768, -32768, 24'hFFFFFE, 32767, -32768, 0,
                                   -32768, 32767, 24'h7FFFFF, 24'hFFFFFF));
        word_q.push_back(make_word(OP_READ, 32767, 32767, 0, 0, 0, 0, 0, 0, 0, 0));
        word_q.push_back(make_word(OP_READ, 15 * 16, 15 * 16, 0, 0, 0, 0, 0, 0, 0, 0));
        word_q.push_back(make_word(OP_DRAW, 32767, 32767, 0, 32767, -32768, 0,
                                   -32768, 32767, 0, 24'h00AA55));
        drain();

        write_reg(CFG_IDX_WIDTH, 0);
        write_reg(CFG_IDX_HEIGHT, 511);
        write_reg(CFG_IDX_SPARE, 7);
        write_reg(CFG_IDX_TOP, 3);
        word_q.push_back(make_word(OP_DRAW, -8, 40, 2, 40, 120, 2, -8, 200, 2, 24'h55AA00));
        word_q.push_back(make_word(OP_READ, 0, 80, 0, 0, 0, 0, 0, 0, 0, 0));
        drain();

        write_reg(CFG_IDX_WIDTH, 256);
        write_reg(CFG_IDX_HEIGHT, 256);
        random_run(200);
        word_q.push_back(make_word(OP_CLEAR, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
        random_run(200);

        send_idle = 62;
        recv_idle = 33;
        write_reg(CFG_IDX_WIDTH, 300);
        write_reg(CFG_IDX_HEIGHT, 20);
        random_run(200);
        random_run(200);

        send_idle = 0;
        recv_idle = 0;
        write_reg(CFG_IDX_WIDTH, 1);
        write_reg(CFG_IDX_HEIGHT, 256);
        random_run(150);
        write_reg(CFG_IDX_WIDTH, 37);
        write_reg(CFG_IDX_HEIGHT, 1);
        random_run(100);
        word_q.push_back(make_word(OP_CLEAR, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
        random_run(150);

        repeat (200) @(posedge clk);
        if (mismatches == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

    always @(negedge clk)
    begin
        if (rst_n)
        begin
            out_if.ready <= ($urandom_range(99) >= recv_idle);
            if (!in_if.valid || word_taken)
            begin
                if (word_q.size() > 0 && $urandom_range(99) >= send_idle)
                begin
                    in_if.valid <= 1'b1;
                    in_if.data <= word_q.pop_front();
                end
                else
                    in_if.valid <= 1'b0;
            end
            word_taken = 1'b0;
        end
    end

    always @(posedge clk)
    begin
        result_word_t want;
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("Mismatches found");
            $finish;
        end
        else
        begin
            if (in_if.valid && in_if.ready)
            begin
                expect_q.push_back(rasterize(in_if.data));
                word_taken = 1'b1;
            end
            if (out_if.valid && out_if.ready)
            begin
                if (expect_q.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("Unexpected result word %h", out_if.data);
                end
                else
                begin
                    want = expect_q.pop_front();
                    if (out_if.data.read_color !== want.read_color
                        || out_if.data.read_depth !== want.read_depth
                        || out_if.data.pixels_written !== want.pixels_written
                        || out_if.data.degenerate !== want.degenerate)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("Result mismatch: expected %h, got %h", want, out_if.data);
                    end
                end
            end
        end
    end

endmodule
